// ===== src/itpp_pkg.sv =====
// package of types and constants for the ip transport protocol parser
`default_nettype none

package itpp_pkg;

	// payload types
	typedef logic [7:0] pkt_byte_t;
	typedef logic [7:0] proto_t;

	// longest packet in bytes, and counter widths that follow from it
	localparam int unsigned MAX_PACKET_LEN = 65535;
	localparam int unsigned CNT_W          = 16;
	localparam int unsigned END_W          = CNT_W + 1;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [END_W-1:0] end_t;

	// fixed byte offsets in the ip header
	localparam cnt_t OFS_VERSION  = cnt_t'(0);
	localparam cnt_t OFS_V4_PROTO = cnt_t'(9);
	localparam cnt_t OFS_V6_NH    = cnt_t'(6);
	localparam cnt_t V4_MIN_LEN   = cnt_t'(20);
	localparam cnt_t V6_HDR_LEN   = cnt_t'(40);

	// ip version codes
	localparam logic [3:0] VER_V4 = 4'd4;
	localparam logic [3:0] VER_V6 = 4'd6;

	// next header codes
	localparam proto_t NH_HOPBYHOP = 8'd0;
	localparam proto_t NH_TCP      = 8'd6;
	localparam proto_t NH_UDP      = 8'd17;
	localparam proto_t NH_ROUTING  = 8'd43;
	localparam proto_t NH_FRAGMENT = 8'd44;
	localparam proto_t NH_AH       = 8'd51;
	localparam proto_t NH_NONE     = 8'd59;
	localparam proto_t NH_DESTOPTS = 8'd60;

	// fixed fragment header length
	localparam end_t FRAG_LEN = end_t'(8);

endpackage

`default_nettype wire

// ===== src/itpp_if.sv =====
// request channels of the ip transport protocol parser
`default_nettype none

interface itpp_pkt_if;
	import itpp_pkg::*;

	logic      valid;
	logic      ready;
	pkt_byte_t packet_byte;
	logic      last_byte;

	modport source (output valid, output packet_byte, output last_byte, input ready);
	modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

interface itpp_res_if;
	import itpp_pkg::*;

	logic   valid;
	logic   ready;
	proto_t protocol;

	modport source (output valid, output protocol, input ready);
	modport sink   (input valid, input protocol, output ready);
endinterface

`default_nettype wire

// ===== src/ip_transport_protocol_parser_unit.sv =====
// ip transport protocol parser: finds the transport protocol of a byte stream
//
// pkt carries an ip packet one byte per request, from byte 0 up, with
// last_byte set on the final byte. result carries one request per packet,
// issued for its final byte: the transport protocol number, or 0 when the
// packet is malformed, truncated, over 65535 bytes or of an unsupported kind.
// ipv4 answers with byte 9; ipv6 walks the extension header chain (hop-by-hop,
// routing, destination options, fragment, ah) up to tcp or udp.
// each byte is registered once, then one pass of compare and small-add logic
// updates the parse state and, on the final byte, loads the result register.
// result valid rises once the final byte has moved from the input register into the result register.
// throughput is one byte per cycle with no gap between packets while the receiver keeps up.
// when the receiver stalls, bytes that are not final keep flowing; a final
// byte waits in the input register until the result register is free, and
// pkt.ready drops only then.
// reset empties both registers and returns the parse state to the start of
// a packet; no clearing pass is needed.
`default_nettype none

module ip_transport_protocol_parser_unit (
	input wire logic    clk,
	input wire logic    arst_n,
	itpp_pkt_if.sink    pkt,
	itpp_res_if.source  result
);
	import itpp_pkg::*;

	// input register
	logic      valid_s1;
	pkt_byte_t byte_s1;
	logic      last_s1;

	// parse state
	cnt_t       byte_count_q;
	logic       too_long_q;
	logic [3:0] ip_version_q;
	logic [5:0] v4_header_len_q;
	proto_t     v4_protocol_q;
	proto_t     cur_nh_q;
	cnt_t       ext_start_q;
	end_t       ext_end_q;
	proto_t     follow_nh_q;
	logic       failed_q;
	logic       done_q;

	// result register
	logic   res_valid_q;
	proto_t res_proto_q;

	// next state
	cnt_t       byte_count_d;
	logic       too_long_d;
	logic [3:0] ip_version_d;
	logic [5:0] v4_header_len_d;
	proto_t     v4_protocol_d;
	proto_t     cur_nh_d;
	cnt_t       ext_start_d;
	end_t       ext_end_d;
	proto_t     follow_nh_d;
	logic       failed_d;
	logic       done_d;
	proto_t     proto_d;

	logic advance;
	logic judge;
	proto_t judge_nh;
	end_t idx_ext;
	end_t start_ext;
	end_t new_end;

	// a final byte moves on only when the result register can take it
	assign advance   = valid_s1 && (!last_s1 || !res_valid_q || result.ready);
	assign pkt.ready = !valid_s1 || advance;

	assign result.valid    = res_valid_q;
	assign result.protocol = res_proto_q;

	// per-byte parse step
	always_comb begin
		byte_count_d    = byte_count_q;
		too_long_d      = too_long_q;
		ip_version_d    = ip_version_q;
		v4_header_len_d = v4_header_len_q;
		v4_protocol_d   = v4_protocol_q;
		cur_nh_d        = cur_nh_q;
		ext_start_d     = ext_start_q;
		ext_end_d       = ext_end_q;
		follow_nh_d     = follow_nh_q;
		failed_d        = failed_q;
		done_d          = done_q;
		judge           = 1'b0;
		judge_nh        = byte_s1;
		idx_ext         = {1'b0, byte_count_q};
		start_ext       = {1'b0, ext_start_q};
		new_end         = ext_end_q;
		proto_d         = '0;

		if (too_long_q || 32'(byte_count_q) >= MAX_PACKET_LEN) begin
			too_long_d = 1'b1;
		end else begin
			if (byte_count_q == OFS_VERSION) begin
				ip_version_d    = byte_s1[7:4];
				v4_header_len_d = {byte_s1[3:0], 2'b00};
			end
			if (byte_count_q == OFS_V4_PROTO)
				v4_protocol_d = byte_s1;

			// ipv6 extension header walk
			if (ip_version_d == VER_V6) begin
				if (byte_count_q == OFS_V6_NH) begin
					cur_nh_d = byte_s1;
					judge    = 1'b1;
					judge_nh = byte_s1;
				end else if (byte_count_q >= V6_HDR_LEN && !done_q && !failed_q) begin
					if (byte_count_q == ext_start_q) begin
						follow_nh_d = byte_s1;
						if (cur_nh_q == NH_FRAGMENT)
							ext_end_d = start_ext + FRAG_LEN;
					end else if (idx_ext == start_ext + end_t'(1)) begin
						case (cur_nh_q)
							NH_HOPBYHOP, NH_ROUTING, NH_DESTOPTS:
								new_end = start_ext
									+ end_t'({end_t'(byte_s1) + end_t'(1), 3'b000});
							NH_AH:
								new_end = start_ext
									+ end_t'({end_t'(byte_s1) + end_t'(2), 2'b00});
							default:
								new_end = ext_end_q;
						endcase
						ext_end_d = new_end;
						if (32'(new_end) > MAX_PACKET_LEN)
							failed_d = 1'b1;
					end else if (idx_ext > start_ext + end_t'(1)
							&& idx_ext + end_t'(1) == ext_end_q) begin
						cur_nh_d    = follow_nh_q;
						ext_start_d = ext_end_q[CNT_W-1:0];
						judge       = 1'b1;
						judge_nh    = follow_nh_q;
					end
				end
			end

			// header type check
			if (judge) begin
				case (judge_nh)
					NH_TCP, NH_UDP:
						done_d = 1'b1;
					NH_HOPBYHOP, NH_ROUTING, NH_DESTOPTS, NH_FRAGMENT, NH_AH: ;
					default:
						failed_d = 1'b1;
				endcase
			end

			byte_count_d = byte_count_q + cnt_t'(1);
		end

		// verdict on the final byte
		if (!too_long_d) begin
			if (ip_version_d == VER_V4) begin
				if (byte_count_d >= V4_MIN_LEN && cnt_t'(v4_header_len_d) >= V4_MIN_LEN
						&& cnt_t'(v4_header_len_d) <= byte_count_d)
					proto_d = v4_protocol_d;
			end else if (ip_version_d == VER_V6) begin
				if (byte_count_d >= V6_HDR_LEN && done_d && !failed_d)
					proto_d = cur_nh_d;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.ready && pkt.valid) begin
			byte_s1 <= pkt.packet_byte;
			last_s1 <= pkt.last_byte;
		end
	end

	// parse state, back to start after each final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q    <= '0;
			too_long_q      <= 1'b0;
			ip_version_q    <= '0;
			v4_header_len_q <= '0;
			v4_protocol_q   <= '0;
			cur_nh_q        <= '0;
			ext_start_q     <= V6_HDR_LEN;
			ext_end_q       <= '0;
			follow_nh_q     <= '0;
			failed_q        <= 1'b0;
			done_q          <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				byte_count_q    <= '0;
				too_long_q      <= 1'b0;
				ip_version_q    <= '0;
				v4_header_len_q <= '0;
				v4_protocol_q   <= '0;
				cur_nh_q        <= '0;
				ext_start_q     <= V6_HDR_LEN;
				ext_end_q       <= '0;
				follow_nh_q     <= '0;
				failed_q        <= 1'b0;
				done_q          <= 1'b0;
			end else begin
				byte_count_q    <= byte_count_d;
				too_long_q      <= too_long_d;
				ip_version_q    <= ip_version_d;
				v4_header_len_q <= v4_header_len_d;
				v4_protocol_q   <= v4_protocol_d;
				cur_nh_q        <= cur_nh_d;
				ext_start_q     <= ext_start_d;
				ext_end_q       <= ext_end_d;
				follow_nh_q     <= follow_nh_d;
				failed_q        <= failed_d;
				done_q          <= done_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1)
			res_proto_q <= proto_d;
	end

endmodule

`default_nettype wire

// ===== tb/ip_transport_protocol_parser_unit_test.sv =====
// testbench of the ip transport protocol parser: byte streams in, protocol numbers checked
`default_nettype none

module ip_transport_protocol_parser_unit_test;
	import itpp_pkg::*;

	localparam int          CLK_PERIOD     = 4;
	localparam int          RESET_CYCLES   = 5;
	localparam int          DRAIN_CYCLES   = 8;
	localparam int          HOLD_CYCLES    = 200;
	localparam int          TIMEOUT_CYCLES = 1500000;
	localparam int          REPORT_LIMIT   = 30;
	localparam int unsigned RANDOM_BYTES   = 300;
	localparam int unsigned RANDOM_PACKETS = 8;
	localparam int unsigned OPT_UNIT       = 8;
	localparam int unsigned AH_UNIT        = 4;

	logic clk = 1'b0;
	logic arst_n;

	itpp_pkt_if pkt ();
	itpp_res_if res ();

	ip_transport_protocol_parser_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt.sink),
		.result (res.source)
	);

	// clock
	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// predicted parse state
	cnt_t       rx_count;
	logic       over_length;
	logic [3:0] version_seen;
	logic [5:0] v4_hlen;
	proto_t     v4_proto_seen;
	proto_t     cur_nh;
	cnt_t       hdr_start;
	end_t       hdr_end;
	proto_t     nh_pending;
	logic       chain_bad;
	logic       chain_ok;

	proto_t      expected_protocols[$];
	pkt_byte_t   frame[$];
	int          mismatch_count = 0;
	int unsigned results_seen   = 0;

	// idling controls
	logic        src_quiet;
	logic        sink_quiet;
	logic        hold_request;
	int unsigned sink_wait;
	int unsigned sink_draw;
	int unsigned hold_left;

	// mismatch report
	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("mismatch: %s", what);
	endtask

	function automatic void clear_parse_state();
		rx_count      = '0;
		over_length   = 1'b0;
		version_seen  = '0;
		v4_hlen       = '0;
		v4_proto_seen = '0;
		cur_nh        = '0;
		hdr_start     = V6_HDR_LEN;
		hdr_end       = '0;
		nh_pending    = '0;
		chain_bad     = 1'b0;
		chain_ok      = 1'b0;
	endfunction

	// tcp or udp ends the walk, any unknown type breaks it
	function automatic void classify_nh();
		if (cur_nh == NH_TCP || cur_nh == NH_UDP)
			chain_ok = 1'b1;
		else if (cur_nh != NH_HOPBYHOP && cur_nh != NH_ROUTING && cur_nh != NH_DESTOPTS &&
		         cur_nh != NH_FRAGMENT && cur_nh != NH_AH)
			chain_bad = 1'b1;
	endfunction

	// ipv6 extension header walk for one byte at offset at
	function automatic void walk_chain(input int unsigned at, input pkt_byte_t value);
		proto_t      kind;
		int unsigned start;
		kind  = cur_nh;
		start = hdr_start;
		if (at == OFS_V6_NH) begin
			cur_nh = value;
			classify_nh();
		end else if (at >= V6_HDR_LEN && !chain_ok && !chain_bad) begin
			if (at == start) begin
				nh_pending = value;
				if (kind == NH_FRAGMENT)
					hdr_end = end_t'(start + FRAG_LEN);
			end else if (at == start + 1) begin
				if (kind == NH_HOPBYHOP || kind == NH_ROUTING || kind == NH_DESTOPTS)
					hdr_end = end_t'(start + (value + 1) * OPT_UNIT);
				else if (kind == NH_AH)
					hdr_end = end_t'(start + (value + 2) * AH_UNIT);
				if (hdr_end > MAX_PACKET_LEN)
					chain_bad = 1'b1;
			end else if (at > start + 1 && at + 1 == hdr_end) begin
				cur_nh    = nh_pending;
				hdr_start = cnt_t'(hdr_end);
				classify_nh();
			end
		end
	endfunction

	// predicted protocol for one accepted byte
	function automatic void track_byte(input pkt_byte_t value, input logic final_byte,
	                                   output logic has_result, output proto_t proto);
		int unsigned len;
		has_result = 1'b0;
		proto      = '0;
		if (over_length || rx_count >= MAX_PACKET_LEN) begin
			over_length = 1'b1;
		end else begin
			if (rx_count == OFS_VERSION) begin
				version_seen = value[7:4];
				v4_hlen      = {value[3:0], 2'b00};
			end
			if (rx_count == OFS_V4_PROTO)
				v4_proto_seen = value;
			if (version_seen == VER_V6)
				walk_chain(rx_count, value);
			rx_count = rx_count + 1'b1;
		end
		if (final_byte) begin
			has_result = 1'b1;
			len        = rx_count;
			if (!over_length) begin
				if (version_seen == VER_V4) begin
					if (len >= V4_MIN_LEN && v4_hlen >= V4_MIN_LEN && v4_hlen <= len)
						proto = v4_proto_seen;
				end else if (version_seen == VER_V6) begin
					if (len >= V6_HDR_LEN && chain_ok && !chain_bad)
						proto = cur_nh;
				end
			end
			clear_parse_state();
		end
	endfunction

	// packet builders
	function automatic void fill_frame(input int unsigned len, input pkt_byte_t value);
		frame.delete();
		repeat (len) frame.push_back(value);
	endfunction

	function automatic void start_noise(input int unsigned len);
		frame.delete();
		repeat (len) frame.push_back(pkt_byte_t'($urandom));
	endfunction

	function automatic void add_pad(input int unsigned count);
		repeat (count) frame.push_back(pkt_byte_t'($urandom));
	endfunction

	function automatic void truncate_to(input int unsigned len);
		while (frame.size() > len)
			void'(frame.pop_back());
	endfunction

	function automatic void start_v4(input int unsigned len, input logic [3:0] ihl,
	                                 input proto_t proto);
		start_noise(len);
		frame[0] = {VER_V4, ihl};
		if (len > OFS_V4_PROTO)
			frame[OFS_V4_PROTO] = proto;
	endfunction

	function automatic void start_v6(input proto_t first_nh);
		start_noise(V6_HDR_LEN);
		frame[0]         = {VER_V6, frame[0][3:0]};
		frame[OFS_V6_NH] = first_nh;
	endfunction

	function automatic void add_ext(input proto_t kind, input proto_t next, input pkt_byte_t len);
		int unsigned size;
		if (kind == NH_FRAGMENT)
			size = FRAG_LEN;
		else if (kind == NH_AH)
			size = (len + 2) * AH_UNIT;
		else
			size = (len + 1) * OPT_UNIT;
		frame.push_back(next);
		frame.push_back(len);
		add_pad(size - 2);
	endfunction

	function automatic proto_t pick_ext();
		case ($urandom_range(4, 0))
			0:       return NH_HOPBYHOP;
			1:       return NH_ROUTING;
			2:       return NH_DESTOPTS;
			3:       return NH_FRAGMENT;
			default: return NH_AH;
		endcase
	endfunction

	// well-formed ipv6 chain with random content, mostly small headers
	function automatic void random_v6();
		int unsigned depth;
		proto_t      kind;
		proto_t      next;
		proto_t      tail;
		pkt_byte_t   len;
		case ($urandom_range(9, 0))
			0:       tail = NH_NONE;
			1:       tail = proto_t'($urandom);
			2, 3, 4: tail = NH_UDP;
			default: tail = NH_TCP;
		endcase
		depth = $urandom_range(4, 0);
		kind  = (depth == 0) ? tail : pick_ext();
		start_v6(kind);
		for (int unsigned d = 0; d < depth; d++) begin
			next = (d == depth - 1) ? tail : pick_ext();
			len  = ($urandom_range(15, 0) == 0) ? pkt_byte_t'($urandom) :
			       pkt_byte_t'($urandom_range(3, 0));
			add_ext(kind, next, len);
			kind = next;
		end
		add_pad($urandom_range(8, 0));
	endfunction

	function automatic void random_v4();
		int unsigned len;
		logic [3:0]  ihl;
		len = ($urandom_range(3, 0) == 0) ? $urandom_range(19, 1) : $urandom_range(60, 20);
		ihl = ($urandom_range(4, 0) == 0) ? 4'($urandom) : 4'($urandom_range(15, 5));
		start_v4(len, ihl, proto_t'($urandom));
	endfunction

	function automatic void random_noise();
		start_noise($urandom_range(48, 1));
		if ($urandom_range(1, 0) == 0)
			frame[0] = {VER_V6, frame[0][3:0]};
	endfunction

	task automatic set_idle(input logic quiet);
		src_quiet = quiet;
		sink_quiet <= quiet;
	endtask

	// one byte request, with its expectation taken on acceptance
	task automatic send_byte(input pkt_byte_t value, input logic final_byte);
		int unsigned gap;
		logic        has_result;
		proto_t      proto;
		gap = src_quiet ? 0 : $urandom_range(13, 0);
		if (gap != 0) begin
			pkt.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pkt.valid       <= 1'b1;
		pkt.packet_byte <= value;
		pkt.last_byte   <= final_byte;
		do @(posedge clk); while (!pkt.ready);
		track_byte(value, final_byte, has_result, proto);
		if (has_result)
			expected_protocols.push_back(proto);
	endtask

	task automatic send_frame();
		int unsigned count;
		count = frame.size();
		for (int unsigned i = 0; i < count; i++)
			send_byte(frame[i], i == count - 1);
	endtask

	task automatic wait_drained();
		pkt.valid <= 1'b0;
		while (expected_protocols.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ipv4 length and header length rules
	task automatic test_ipv4_header();
		set_idle(1'b0);
		start_v4(20, 4'd5, NH_TCP);       send_frame();
		start_v4(60, 4'd15, 8'd255);      send_frame();
		start_v4(24, 4'd6, NH_UDP);       send_frame();
		start_v4(20, 4'd4, NH_TCP);       send_frame();
		start_v4(20, 4'd6, NH_TCP);       send_frame();
		start_v4(19, 4'd5, NH_TCP);       send_frame();
		start_v4(40, 4'd0, NH_UDP);       send_frame();
		start_v4(10, 4'd5, NH_UDP);       send_frame();
		start_v4(1, 4'd5, NH_UDP);        send_frame();
		start_v4(30, 4'd5, 8'd0);         send_frame();
		wait_drained();
	endtask

	// ipv6 extension header walk, its endings and its failures
	task automatic test_ipv6_chain();
		set_idle(1'b0);
		start_v6(NH_TCP);                                  send_frame();
		start_v6(NH_UDP);                                  add_pad(7);  send_frame();
		start_v6(NH_TCP);                                  truncate_to(39); send_frame();
		start_v6(NH_HOPBYHOP); add_ext(NH_HOPBYHOP, NH_TCP, 8'd0);       send_frame();
		start_v6(NH_ROUTING);  add_ext(NH_ROUTING, NH_UDP, 8'd1);        send_frame();
		start_v6(NH_DESTOPTS); add_ext(NH_DESTOPTS, NH_UDP, 8'd2);       add_pad(5);
		send_frame();
		start_v6(NH_FRAGMENT); add_ext(NH_FRAGMENT, NH_TCP, 8'hff);      send_frame();
		start_v6(NH_AH);       add_ext(NH_AH, NH_UDP, 8'd0);             send_frame();
		start_v6(NH_AH);       add_ext(NH_AH, NH_TCP, 8'd9);             add_pad(2);
		send_frame();
		// long mixed chain
		start_v6(NH_HOPBYHOP);
		add_ext(NH_HOPBYHOP, NH_ROUTING, 8'd3);
		add_ext(NH_ROUTING, NH_FRAGMENT, 8'd0);
		add_ext(NH_FRAGMENT, NH_AH, 8'd0);
		add_ext(NH_AH, NH_DESTOPTS, 8'd1);
		add_ext(NH_DESTOPTS, NH_UDP, 8'd0);
		add_pad(3);
		send_frame();
		// no next header and unknown types
		start_v6(NH_NONE);                                 add_pad(8);  send_frame();
		start_v6(NH_HOPBYHOP); add_ext(NH_HOPBYHOP, NH_NONE, 8'd0);      send_frame();
		start_v6(8'd99);                                   send_frame();
		start_v6(8'hff);                                   send_frame();
		start_v6(NH_ROUTING);  add_ext(NH_ROUTING, 8'd200, 8'd0);        add_pad(4);
		send_frame();
		// header running past the final byte
		start_v6(NH_HOPBYHOP); add_ext(NH_HOPBYHOP, NH_TCP, 8'd3);
		truncate_to(frame.size() - 1);
		send_frame();
		// other versions and degenerate contents
		fill_frame(40, 8'h00);                             send_frame();
		fill_frame(64, 8'hff);                             send_frame();
		start_v6(NH_TCP);      frame[0] = {4'd5, 4'd0};    send_frame();
		fill_frame(1, {VER_V6, 4'd0});                     send_frame();
		wait_drained();
	endtask

	// receiver holds off while short packets keep coming, so the input stalls
	task automatic test_result_stall();
		set_idle(1'b1);
		hold_request <= 1'b1;
		@(posedge clk);
		hold_request <= 1'b0;
		for (int n = 0; n < 12; n++) begin
			if (n % 3 == 0)
				start_v4(20, 4'd5, proto_t'($urandom));
			else
				start_noise($urandom_range(3, 1));
			send_frame();
		end
		wait_drained();
	endtask

	// random packets: mostly well formed, some noise and cut short
	task automatic test_random_traffic();
		int unsigned bytes_sent;
		int unsigned packets_sent;
		int unsigned pick;
		bytes_sent   = 0;
		packets_sent = 0;
		while (bytes_sent < RANDOM_BYTES || packets_sent < RANDOM_PACKETS) begin
			set_idle($urandom_range(3, 0) == 0);
			pick = $urandom_range(99, 0);
			if (pick < 50)
				random_v6();
			else if (pick < 75)
				random_v4();
			else
				random_noise();
			if ($urandom_range(9, 0) == 0 && frame.size() > 1)
				truncate_to($urandom_range(frame.size() - 1, 1));
			bytes_sent += frame.size();
			packets_sent++;
			send_frame();
		end
		wait_drained();
	endtask

	// result receiver: random wait after each request unless quiet, plus a long hold on demand
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			sink_wait <= 0;
			hold_left <= 0;
		end else if (hold_request) begin
			hold_left <= HOLD_CYCLES;
			res.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res.ready <= (hold_left == 1);
		end else if (res.valid && res.ready) begin
			sink_draw = sink_quiet ? 0 : $urandom_range(13, 0);
			sink_wait <= sink_draw;
			res.ready <= (sink_draw == 0);
		end else if (sink_wait != 0) begin
			sink_wait <= sink_wait - 1;
			res.ready <= (sink_wait == 1);
		end else begin
			res.ready <= 1'b1;
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		proto_t want;
		if (arst_n && res.valid && res.ready) begin
			if (expected_protocols.size() == 0) begin
				report_mismatch($sformatf("result %0d: protocol %0d with no packet pending",
				                          results_seen, res.protocol));
			end else begin
				want = expected_protocols[0];
				expected_protocols.delete(0);
				if (res.protocol !== want)
					report_mismatch($sformatf("result %0d: protocol %0d, expected %0d",
					                          results_seen, res.protocol, want));
			end
			results_seen++;
		end
	end

	// test sequence
	initial begin
		arst_n          <= 1'b0;
		pkt.valid       <= 1'b0;
		pkt.packet_byte <= '0;
		pkt.last_byte   <= 1'b0;
		hold_request    <= 1'b0;
		sink_quiet      <= 1'b0;
		src_quiet = 1'b0;
		clear_parse_state();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ipv4_header();
		test_ipv6_chain();
		test_result_stall();
		test_random_traffic();
		wait_drained();
		if (mismatch_count == 0)
			$display("ip_transport_protocol_parser_unit_test OK");
		else
			$display("ip_transport_protocol_parser_unit_test NOT OK");
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("ip_transport_protocol_parser_unit_test NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
src/itpp_pkg.sv
src/itpp_if.sv
src/ip_transport_protocol_parser_unit.sv
tb/ip_transport_protocol_parser_unit_test.sv
